@@ rtl/pavr_pkg.sv @@
// shared types, constants and the arctangent table of the vector rotator
`default_nettype none

package pavr_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int OUT_BITS      = SAMPLE_BITS + 1;

    localparam int TURN_BITS     = 32;
    localparam int ATAN_ENTRIES  = 24;
    localparam int Z_W           = TURN_BITS + 1;
    localparam int XY_W          = 33;
    localparam int TRIG_W        = 16;
    localparam int FRAC_SHIFT    = 15;
    localparam logic [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

    localparam int S_TDATA_W = ((ANGLE_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * OUT_BITS + ANGLE_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ADD  = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0]  heading;
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] y;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // atan(2^-i) with 2^32 per full turn
    function automatic logic [TURN_BITS-1:0] atan_turn32(input int idx);
        logic [TURN_BITS-1:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41721;
            15:      v = 32'd20860;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2607;
            19:      v = 32'd1303;
            20:      v = 32'd651;
            21:      v = 32'd325;
            22:      v = 32'd162;
            23:      v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pavr_front.sv @@
// input side: heading accumulator and queue write
`default_nettype none

module pavr_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pavr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic [0:0]                        s_axis_tuser,
    input  wire pavr_pkg::t_q_status               i_q_status,
    output logic                                   o_push,
    output pavr_pkg::t_entry                       o_entry
);
    import pavr_pkg::*;

    logic signed [ANGLE_BITS-1:0]  r_heading;
    logic signed [ANGLE_BITS-1:0]  n_heading;
    logic signed [ANGLE_BITS-1:0]  angle;
    t_op                           op;

    assign angle         = s_axis_tdata[ANGLE_BITS-1:0];
    assign op            = t_op'(s_axis_tuser[0]);
    assign s_axis_tready = !i_q_status.full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        unique case (op)
            OP_ADD:  n_heading = r_heading + angle;
            OP_LOAD: n_heading = angle;
            default: n_heading = angle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
        end else if (o_push) begin
            r_heading <= n_heading;
        end
    end

    assign o_entry.heading = n_heading;
    assign o_entry.x       = s_axis_tdata[ANGLE_BITS +: SAMPLE_BITS];
    assign o_entry.y       = s_axis_tdata[ANGLE_BITS + SAMPLE_BITS +: SAMPLE_BITS];

endmodule

`default_nettype wire

@@ rtl/pavr_queue.sv @@
// short queue between the heading front and the rotation pipeline
`default_nettype none

module pavr_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire pavr_pkg::t_entry   i_entry,
    input  wire logic               i_pop,
    output pavr_pkg::t_entry        o_entry,
    output pavr_pkg::t_q_status     o_status
);
    import pavr_pkg::*;

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr;
    logic [QUEUE_AW-1:0]    r_rd;
    logic [QUEUE_AW:0]      r_cnt;
    logic                   do_pop;

    assign o_status.full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_pop         = i_pop && !o_status.empty;
    assign o_entry        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/pavr_back.sv @@
// rotation pipeline: cordic sine/cosine, products, rounding and output register
`default_nettype none

module pavr_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pavr_pkg::t_entry                  i_entry,
    input  wire pavr_pkg::t_q_status               i_q_status,
    output logic                                   o_pop,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [pavr_pkg::M_TDATA_W-1:0]         m_axis_tdata
);
    import pavr_pkg::*;

    localparam int PROD_W = TRIG_W + SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TSH_W  = XY_W + 1 - FRAC_SHIFT;
    localparam int SSH_W  = SUM_W - FRAC_SHIFT;

    // whole pipeline moves together; it only stops when the output is held
    logic en;
    assign en    = !m_axis_tvalid || m_axis_tready;
    assign o_pop = en;

    logic signed [Z_W-1:0]         r_z    [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]        r_x    [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]        r_y    [CORDIC_STAGES+1];
    logic                          r_flip [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]        r_vld;
    t_entry                        r_pay  [CORDIC_STAGES+1];

    // entry stage: fold the back half-plane onto the front one
    logic [TURN_BITS-1:0] z32;
    logic [TURN_BITS-1:0] zf;
    logic                 flip;

    assign z32  = TURN_BITS'(unsigned'(i_entry.heading)) << (TURN_BITS - ANGLE_BITS);
    assign flip = z32[TURN_BITS-1] ^ z32[TURN_BITS-2];
    assign zf   = flip ? {~z32[TURN_BITS-1], z32[TURN_BITS-2:0]} : z32;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z[0]    <= $signed({zf[TURN_BITS-1], zf});
            r_x[0]    <= $signed(GAIN_Q30);
            r_y[0]    <= '0;
            r_flip[0] <= flip;
            r_pay[0]  <= i_entry;
        end
    end

    genvar k;
    generate
        for (k = 0; k < CORDIC_STAGES; k++) begin : g_stage
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;
            logic signed [Z_W-1:0]  at;

            assign dx = r_y[k] >>> k;
            assign dy = r_x[k] >>> k;
            assign at = $signed({1'b0, atan_turn32(k)});

            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!r_z[k][Z_W-1]) begin
                        r_x[k+1] <= r_x[k] - dx;
                        r_y[k+1] <= r_y[k] + dy;
                        r_z[k+1] <= r_z[k] - at;
                    end else begin
                        r_x[k+1] <= r_x[k] + dx;
                        r_y[k+1] <= r_y[k] - dy;
                        r_z[k+1] <= r_z[k] + at;
                    end
                    r_flip[k+1] <= r_flip[k];
                    r_pay[k+1]  <= r_pay[k];
                end
            end
        end
    endgenerate

    // round the q30 cosine/sine to q1.15 with saturation
    logic signed [XY_W-1:0]   xf;
    logic signed [XY_W-1:0]   yf;
    logic signed [XY_W:0]     xt;
    logic signed [XY_W:0]     yt;
    logic signed [XY_W:0]     xs;
    logic signed [XY_W:0]     ys;
    logic signed [TSH_W-1:0]  xn;
    logic signed [TSH_W-1:0]  yn;
    logic signed [TRIG_W-1:0] c_val;
    logic signed [TRIG_W-1:0] s_val;

    localparam logic signed [TSH_W-1:0] TRIG_MAX = $signed(TSH_W'((1 << (TRIG_W - 1)) - 1));
    localparam logic signed [TSH_W-1:0] TRIG_MIN = -$signed(TSH_W'(1 << (TRIG_W - 1)));
    localparam logic signed [XY_W:0]    HALF_T   = $signed((XY_W+1)'(1 << (FRAC_SHIFT - 1)));

    always_comb begin
        xf = r_flip[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
        yf = r_flip[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];
        xt = $signed({xf[XY_W-1], xf}) + HALF_T;
        yt = $signed({yf[XY_W-1], yf}) + HALF_T;
        xs = xt >>> FRAC_SHIFT;
        ys = yt >>> FRAC_SHIFT;
        xn = xs[TSH_W-1:0];
        yn = ys[TSH_W-1:0];
        if (xn > TRIG_MAX) begin
            c_val = TRIG_MAX[TRIG_W-1:0];
        end else if (xn < TRIG_MIN) begin
            c_val = TRIG_MIN[TRIG_W-1:0];
        end else begin
            c_val = xn[TRIG_W-1:0];
        end
        if (yn > TRIG_MAX) begin
            s_val = TRIG_MAX[TRIG_W-1:0];
        end else if (yn < TRIG_MIN) begin
            s_val = TRIG_MIN[TRIG_W-1:0];
        end else begin
            s_val = yn[TRIG_W-1:0];
        end
    end

    logic signed [TRIG_W-1:0] r_c;
    logic signed [TRIG_W-1:0] r_s;
    t_entry                   r_pay_t;
    logic                     r_vld_t;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c     <= c_val;
            r_s     <= s_val;
            r_pay_t <= r_pay[CORDIC_STAGES];
        end
    end

    logic signed [PROD_W-1:0] r_cx;
    logic signed [PROD_W-1:0] r_sy;
    logic signed [PROD_W-1:0] r_cy;
    logic signed [PROD_W-1:0] r_sx;
    logic [ANGLE_BITS-1:0]    r_head_p;
    logic                     r_vld_p;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx     <= r_c * r_pay_t.x;
            r_sy     <= r_s * r_pay_t.y;
            r_cy     <= r_c * r_pay_t.y;
            r_sx     <= r_s * r_pay_t.x;
            r_head_p <= r_pay_t.heading;
        end
    end

    // product sums rounded half up and saturated to the output width
    localparam logic signed [SSH_W-1:0] OUT_MAX = $signed(SSH_W'((1 << (OUT_BITS - 1)) - 1));
    localparam logic signed [SSH_W-1:0] OUT_MIN = -$signed(SSH_W'(1 << (OUT_BITS - 1)));
    localparam logic signed [SUM_W-1:0] HALF_P  = $signed(SUM_W'(1 << (FRAC_SHIFT - 1)));

    logic signed [SUM_W-1:0]    xsum;
    logic signed [SUM_W-1:0]    ysum;
    logic signed [SUM_W-1:0]    xsh;
    logic signed [SUM_W-1:0]    ysh;
    logic signed [SSH_W-1:0]    xw;
    logic signed [SSH_W-1:0]    yw;
    logic signed [OUT_BITS-1:0] x_res;
    logic signed [OUT_BITS-1:0] y_res;

    always_comb begin
        xsum = $signed({r_cx[PROD_W-1], r_cx}) - $signed({r_sy[PROD_W-1], r_sy}) + HALF_P;
        ysum = $signed({r_cy[PROD_W-1], r_cy}) + $signed({r_sx[PROD_W-1], r_sx}) + HALF_P;
        xsh  = xsum >>> FRAC_SHIFT;
        ysh  = ysum >>> FRAC_SHIFT;
        xw   = xsh[SSH_W-1:0];
        yw   = ysh[SSH_W-1:0];
        if (xw > OUT_MAX) begin
            x_res = OUT_MAX[OUT_BITS-1:0];
        end else if (xw < OUT_MIN) begin
            x_res = OUT_MIN[OUT_BITS-1:0];
        end else begin
            x_res = xw[OUT_BITS-1:0];
        end
        if (yw > OUT_MAX) begin
            y_res = OUT_MAX[OUT_BITS-1:0];
        end else if (yw < OUT_MIN) begin
            y_res = OUT_MIN[OUT_BITS-1:0];
        end else begin
            y_res = yw[OUT_BITS-1:0];
        end
    end

    logic [M_TDATA_W-1:0] r_tdata;
    logic                 r_tvalid;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= M_TDATA_W'({r_head_p, y_res, x_res});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_vld_t  <= 1'b0;
            r_vld_p  <= 1'b0;
            r_tvalid <= 1'b0;
        end else if (en) begin
            r_vld    <= {r_vld[CORDIC_STAGES-1:0], !i_q_status.empty};
            r_vld_t  <= r_vld[CORDIC_STAGES];
            r_vld_p  <= r_vld_t;
            r_tvalid <= r_vld_p;
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;

endmodule

`default_nettype wire

@@ rtl/phase_accumulating_vector_rotator.sv @@
// top level of the phase-accumulating vector rotator
//
//  channel  dir  tdata fields (low bit up)              tuser
//  s_axis   in   angle[15:0] x_in[31:16] y_in[47:32]    operation[0]
//  m_axis   out  x_out[16:0] y_out[33:17] heading[49:34] -
//               (bits 55:50 zero)
//
// one transaction per cycle in and out while the output is not held; data passes through
// the queue, entry stage, one stage per micro-rotation, rounding, products and output
// reset clears the heading to zero angle and empties the queue and pipeline
// a held output stalls the whole rotation pipeline; the four-entry queue then
// fills and s_axis_tready drops while the queue is full
`default_nettype none

module phase_accumulating_vector_rotator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pavr_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // angle, x_in, y_in
    input  wire logic [0:0]                        s_axis_tuser,   // operation
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [pavr_pkg::M_TDATA_W-1:0]         m_axis_tdata    // x_out, y_out, heading
);
    import pavr_pkg::*;

    t_q_status q_status;
    t_entry    push_entry;
    t_entry    head_entry;
    logic      push;
    logic      pop;

    pavr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    pavr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    pavr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/pavr_checker.sv @@
// port-level checks for the vector rotator, bound to the top level
`default_nettype none

module pavr_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [pavr_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import pavr_pkg::*;

    localparam int PAY_W = 2 * OUT_BITS + ANGLE_BITS;

    logic [7:0] r_pending;
    logic       in_xact;
    logic       out_xact;

    assign in_xact  = s_axis_tvalid && s_axis_tready;
    assign out_xact = m_axis_tvalid && m_axis_tready;

    // transactions taken in and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            unique case ({in_xact, out_xact})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != '0)
        else $error("output without an outstanding input");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:PAY_W] == '0)
        else $error("output padding bits not zero");

endmodule

bind phase_accumulating_vector_rotator pavr_checker u_pavr_checker (.*);

`default_nettype wire

@@ bench/phase_accumulating_vector_rotator_tb.sv @@
// self-checking bench of the phase-accumulating vector rotator
`default_nettype none

module phase_accumulating_vector_rotator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pavr_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_TAIL   = 120;   // last items go through with no idling
    localparam int DRAIN_CYCLES = 2 * (CORDIC_STAGES + 5);
    localparam longint CORDIC_GAIN = 64'sd652032874;   // 0.607252935 in Q30

    // atan(2^-i), 2^32 per full turn
    localparam longint ARCTAN_STEP [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860, 10430, 5215,
        2607, 1303, 651, 325, 162, 81
    };

    typedef struct {
        t_op                           op;
        logic [ANGLE_BITS-1:0]         angle;
        logic signed [SAMPLE_BITS-1:0] x_in;
        logic signed [SAMPLE_BITS-1:0] y_in;
    } t_move;

    typedef struct {
        logic signed [OUT_BITS-1:0]   x_out;
        logic signed [OUT_BITS-1:0]   y_out;
        logic signed [ANGLE_BITS-1:0] heading;
    } t_rotated;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;   // angle, x_in, y_in
    logic [0:0]             s_axis_tuser = '0;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;        // x_out, y_out, heading

    t_move    move_q[$];
    t_rotated rotated_q[$];
    logic [ANGLE_BITS-1:0] tracked_heading = '0;
    int       fail_count = 0;
    int       in_gap = 0;
    int       out_gap = 0;

    phase_accumulating_vector_rotator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // cosine and sine of a heading in Q1.15
    function automatic void heading_trig(input logic [ANGLE_BITS-1:0] hd,
                                         output longint c, output longint s);
        logic [31:0] z;
        logic        flip;
        longint      cx, cy, r, dx, dy;
        z = 32'(hd) << (32 - ANGLE_BITS);
        flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
        // second and third quadrant: rotate by half a turn less, negate at the end
        if (flip)
            z = z + 32'h8000_0000;
        r = longint'($signed(z));
        cx = CORDIC_GAIN;
        cy = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (r >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                r = r - ARCTAN_STEP[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                r = r + ARCTAN_STEP[i];
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        c = clip((cx + 16384) >>> 15, -32768, 32767);
        s = clip((cy + 16384) >>> 15, -32768, 32767);
    endfunction

    function automatic t_rotated rotate_vector(input logic [ANGLE_BITS-1:0] hd,
                                               input logic signed [SAMPLE_BITS-1:0] xi,
                                               input logic signed [SAMPLE_BITS-1:0] yi);
        t_rotated res;
        longint   c, s, lo, hi, xv, yv;
        heading_trig(hd, c, s);
        xv = xi;
        yv = yi;
        lo = -(64'sd1 <<< (OUT_BITS - 1));
        hi = (64'sd1 <<< (OUT_BITS - 1)) - 1;
        res.x_out = OUT_BITS'(clip((c * xv - s * yv + 16384) >>> 15, lo, hi));
        res.y_out = OUT_BITS'(clip((c * yv + s * xv + 16384) >>> 15, lo, hi));
        res.heading = hd;
        return res;
    endfunction

    task automatic queue_move(input t_op op, input int ang, input int xi, input int yi);
        t_move m;
        m.op = op;
        m.angle = ANGLE_BITS'(ang);
        m.x_in = SAMPLE_BITS'(xi);
        m.y_in = SAMPLE_BITS'(yi);
        move_q.push_back(m);
    endtask

    function automatic int pick_sample();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(0, 2) - 1;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int pick_angle();
        int edges [0:9] = '{0, 16384, -16384, -32768, 32767, 16383, -16385, 8192, -8192, 1};
        if ($urandom_range(0, 3) == 0)
            return edges[$urandom_range(0, 9)];
        return int'($signed(16'($urandom)));
    endfunction

    // stimulus driver
    always @(posedge i_clk) begin : drive_moves
        t_move m;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (move_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                in_gap <= $urandom_range(0, 7);
                s_axis_tvalid <= 1'b0;
            end else if (move_q.size() > 0) begin
                m = move_q.pop_front();
                s_axis_tdata <= {m.y_in, m.x_in, m.angle};
                s_axis_tuser <= m.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (move_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // predicts on every input transaction, checks every output transaction
    always @(posedge i_clk) begin : watch_ports
        t_rotated want;
        t_rotated got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (t_op'(s_axis_tuser[0]) == OP_ADD)
                tracked_heading = tracked_heading + s_axis_tdata[ANGLE_BITS-1:0];
            else
                tracked_heading = s_axis_tdata[ANGLE_BITS-1:0];
            rotated_q.push_back(rotate_vector(tracked_heading,
                s_axis_tdata[ANGLE_BITS +: SAMPLE_BITS],
                s_axis_tdata[ANGLE_BITS + SAMPLE_BITS +: SAMPLE_BITS]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x_out = m_axis_tdata[0 +: OUT_BITS];
            got.y_out = m_axis_tdata[OUT_BITS +: OUT_BITS];
            got.heading = m_axis_tdata[2 * OUT_BITS +: ANGLE_BITS];
            if (rotated_q.size() == 0) begin
                $error("unexpected output transaction: x_out %0d y_out %0d heading %0d",
                       got.x_out, got.y_out, got.heading);
                fail_count++;
            end else begin
                want = rotated_q.pop_front();
                if (got.x_out !== want.x_out) begin
                    $error("x_out: expected %0d, got %0d", want.x_out, got.x_out);
                    fail_count++;
                end
                if (got.y_out !== want.y_out) begin
                    $error("y_out: expected %0d, got %0d", want.y_out, got.y_out);
                    fail_count++;
                end
                if (got.heading !== want.heading) begin
                    $error("heading: expected %0d, got %0d", want.heading, got.heading);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        // heading starts at zero angle, so a first add of zero keeps it there
        queue_move(OP_ADD, 0, 32767, 0);
        queue_move(OP_LOAD, 0, -32768, -32768);
        queue_move(OP_LOAD, 16384, 32767, -32768);
        queue_move(OP_LOAD, 16383, 1, -1);
        queue_move(OP_LOAD, -16384, -32768, 32767);
        queue_move(OP_LOAD, -16385, 32767, 32767);
        queue_move(OP_LOAD, -32768, 32767, 32767);
        queue_move(OP_LOAD, 32767, -32768, 0);
        // add across the wrap point and back
        queue_move(OP_ADD, 1, 100, -200);
        queue_move(OP_ADD, -32768, -32768, 32767);
        queue_move(OP_ADD, -1, 0, 0);
        queue_move(OP_ADD, 32767, 12345, -12345);
        queue_move(OP_ADD, -32768, -1, 1);
        // diagonals give the largest magnitudes
        queue_move(OP_LOAD, 8192, -32768, -32768);
        queue_move(OP_LOAD, -8192, 32767, 32767);
        queue_move(OP_LOAD, 24576, 32767, -32768);
        queue_move(OP_LOAD, -24576, -32768, 32767);
        queue_move(OP_ADD, 16384, -32768, -32768);
        queue_move(OP_ADD, 16384, 0, 32767);
        queue_move(OP_ADD, 16384, 32767, 0);
        queue_move(OP_ADD, 16384, -1, -1);
        queue_move(OP_LOAD, 1, 32767, -32768);
        queue_move(OP_LOAD, -1, -32768, 32767);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_move(t_op'($urandom_range(0, 1)), pick_angle(), pick_sample(), pick_sample());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (move_q.size() != 0 || s_axis_tvalid || rotated_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (rotated_q.size() != 0) begin
            $error("%0d output transactions never arrived", rotated_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #1ms;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
